// File: hw/rtl/msi_pkg.sv
// Package with shared types, constants and helpers for the matrix sample integrator.
`timescale 1ns / 1ps
package msi_pkg;

  localparam int unsigned MaxDim    = 8;
  localparam int unsigned CountBits = 16;
  localparam int unsigned Depth     = MaxDim * MaxDim;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned SumW      = 48;

  localparam logic [1:0] RegRule = 2'd0;
  localparam logic [1:0] RegStep = 2'd1;
  localparam logic [1:0] RegDim  = 2'd2;

  // Division by three as a multiplication: ceil(2^35 / 3), exact for dividends below 2^35.
  localparam logic [33:0] ThirdRecip = 34'h2_AAAA_AAAB;
  // Smallest dividend whose third lies beyond 2^31.
  localparam logic [58:0] ThirdSat   = 59'h1_8000_0003;

  // Work a job needs from the back end: the element, its position and sample role.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [IdxW-1:0]    idx;
    logic               fin;
    logic               last;
    logic [CountBits-1:0] cnt;
  } job_t;

  function automatic logic signed [SumW-1:0] sat48(input logic signed [SumW+2:0] v);
    logic signed [SumW+2:0] mx;
    logic signed [SumW+2:0] mn;
    begin
      mx = (SumW+3)'({1'b0, {(SumW-1){1'b1}}});
      mn = -mx - (SumW+3)'(1);
      if (v > mx) sat48 = mx[SumW-1:0];
      else if (v < mn) sat48 = mn[SumW-1:0];
      else sat48 = v[SumW-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/msi_front.sv
// Front end: accepts elements, filters unused positions and tracks the sample count.
`timescale 1ns / 1ps
module msi_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [3:0]             dim_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [31:0]     re_i,
  input  logic signed [31:0]     im_i,
  input  logic [5:0]             idx_i,
  input  logic                   fin_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output msi_pkg::job_t          job_o
);
  import msi_pkg::*;

  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [4:0] dim;
  logic [7:0] used;
  logic keep, last, take;

  always_comb begin
    if (dim_i == 4'd0) dim = 5'd1;
    else if ({1'b0, dim_i} > 5'(MaxDim)) dim = 5'(MaxDim);
    else dim = {1'b0, dim_i};
    used = 8'(dim) * 8'(dim);
    keep = ({2'b0, idx_i} < used) && (32'(idx_i) < Depth);
    last = ({2'b0, idx_i} == used - 8'd1);
  end

  assign in_ready_o  = job_ready_i || !keep;
  assign take        = in_valid_i && in_ready_o && keep;
  assign job_valid_o = in_valid_i && keep;

  always_comb begin
    cnt_d = cnt_q;
    if (take && last) begin
      if (fin_i) cnt_d = '0;
      else if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
    end
    job_o.re   = re_i;
    job_o.im   = im_i;
    job_o.idx  = idx_i[IdxW-1:0];
    job_o.fin  = fin_i;
    job_o.last = last;
    job_o.cnt  = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end
endmodule

// File: hw/rtl/msi_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module msi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  msi_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output msi_pkg::job_t rd_data_o
);
  import msi_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic       wr, rd;

  assign wr_ready_o = fill_q != 2'd2;
  assign rd_valid_o = fill_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      fill_q <= fill_q + 2'(wr) - 2'(rd);
    end
  end
endmodule

// File: hw/rtl/msi_back.sv
// Back end: per-position stores, accumulation and the scaled integral with division.
`timescale 1ns / 1ps
module msi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rule_i,
  input  logic [31:0]         step_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  msi_pkg::job_t       job_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic signed [31:0]  res_re_o,
  output logic signed [31:0]  res_im_o,
  output logic [5:0]          res_idx_o,
  output logic                res_last_o
);
  import msi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_UPD  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Stores, one row per position, re and im packed together.
  logic [63:0]       fp_mem [Depth];
  logic [63:0]       pv_mem [Depth];
  logic [2*SumW-1:0] ps_mem [Depth];
  logic [2*SumW-1:0] ws_mem [Depth];
  logic [63:0]       fp_rd_q, pv_rd_q;
  logic [2*SumW-1:0] ps_rd_q, ws_rd_q;

  job_t job_q;
  logic signed [SumW+4:0] m_q [2];
  logic [2:0]             div_q;
  logic                   part_q;   // component being worked: 0 re, 1 im
  logic [82:0]            prod_q;
  logic [5:0]             ph_q;     // phase within a multiply or a divide step
  logic [32:0]            n_q;      // dividend once any factor of two is taken out
  logic                   big_q;    // quotient lies beyond the signed 32-bit range
  logic signed [31:0]     r_q [2];

  logic fp_we, pv_we, ps_we, ws_we;
  logic [63:0] fp_wd;
  logic [2*SumW-1:0] ps_wd, ws_wd;

  // Combinational numerator and store update for both components.
  logic signed [31:0]     f0 [2], pv [2], cx [2];
  logic signed [SumW-1:0] sp [2], sw [2], nsp [2], nsw [2];
  logic signed [SumW+4:0] mm [2];
  logic [CountBits-1:0]   i;
  logic                   w4;

  always_comb begin
    i  = job_q.cnt;
    w4 = !i[0];  // weight of previous sample (index i-1): odd -> 4
    cx[0] = job_q.re;
    cx[1] = job_q.im;
    for (int c = 0; c < 2; c++) begin
      pv[c] = pv_rd_q[32*c +: 32];
      if (i == '0) begin
        f0[c]  = cx[c];
        nsp[c] = '0;
        nsw[c] = '0;
      end else begin
        f0[c]  = fp_rd_q[32*c +: 32];
        nsp[c] = ps_rd_q[SumW*c +: SumW];
        nsw[c] = ws_rd_q[SumW*c +: SumW];
        if (i >= CountBits'(2)) begin
          nsp[c] = sat48((SumW+3)'(nsp[c]) + (SumW+3)'(pv[c]));
          nsw[c] = sat48((SumW+3)'(nsw[c]) +
                         ((SumW+3)'(pv[c]) <<< (w4 ? 2 : 1)));
        end
      end
      sp[c] = nsp[c];
      sw[c] = nsw[c];
      if (!rule_i || i == CountBits'(1))
        mm[c] = (SumW+5)'(f0[c]) + (SumW+5)'(cx[c]) + ((SumW+5)'(sp[c]) <<< 1);
      else if (!i[0])
        mm[c] = (SumW+5)'(f0[c]) + (SumW+5)'(sw[c]) + (SumW+5)'(cx[c]);
      else
        mm[c] = (((SumW+5)'(f0[c]) + (SumW+5)'(sw[c]) - (SumW+5)'(pv[c])) <<< 1)
              + (SumW+5)'(pv[c]) * 3 + (SumW+5)'(cx[c]) * 3;
    end
  end

  logic signed [SumW+4:0] m_cur;
  logic [SumW+4:0]        mag;
  logic [58:0]            num;
  logic [58:0]            nsh;
  logic                   big;
  logic [66:0]            recip;
  logic [31:0]            quo;

  always_comb begin
    m_cur = m_q[part_q];
    mag   = m_cur[SumW+4] ? (SumW+5)'(-m_cur) : (SumW+5)'(m_cur);
    num   = prod_q[82:24];
    // Division by six is a halving followed by division by three.
    nsh   = (div_q == 3'd3) ? num : (num >> 1);
    big   = (div_q == 3'd2) ? (nsh > 59'h0_8000_0000) : (nsh >= ThirdSat);
    recip = 67'(n_q) * 67'(ThirdRecip);
    quo   = (div_q == 3'd2) ? n_q[31:0] : recip[66:35];
  end

  assign job_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_OUT;
  assign res_re_o    = r_q[0];
  assign res_im_o    = r_q[1];
  assign res_idx_o   = 6'(job_q.idx);
  assign res_last_o  = job_q.last;

  always_comb begin
    fp_we = state_q == S_UPD && i == '0;
    pv_we = state_q == S_UPD;
    ps_we = pv_we;
    ws_we = pv_we;
    fp_wd = {job_q.im, job_q.re};
    ps_wd = {nsp[1], nsp[0]};
    ws_wd = {nsw[1], nsw[0]};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      fp_rd_q <= fp_mem[job_q.idx];
      pv_rd_q <= pv_mem[job_q.idx];
      ps_rd_q <= ps_mem[job_q.idx];
      ws_rd_q <= ws_mem[job_q.idx];
    end
    if (fp_we) fp_mem[job_q.idx] <= fp_wd;
    if (pv_we) pv_mem[job_q.idx] <= fp_wd;
    if (ps_we) ps_mem[job_q.idx] <= ps_wd;
    if (ws_we) ws_mem[job_q.idx] <= ws_wd;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (job_valid_i) state_d = S_READ;
      S_READ: state_d = S_UPD;
      S_UPD:  state_d = !job_q.fin ? S_IDLE : (i == '0) ? S_OUT : S_MUL;
      S_MUL:  if (ph_q == 6'd1) state_d = S_DIV;
      S_DIV:  if (ph_q == 6'd1) state_d = part_q ? S_OUT : S_MUL;
      S_OUT:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (job_valid_i) job_q <= job_i;
      S_UPD: begin
        m_q[0] <= mm[0];
        m_q[1] <= mm[1];
        div_q  <= (!rule_i || i == CountBits'(1)) ? 3'd2 : (!i[0]) ? 3'd3 : 3'd6;
        part_q <= 1'b0;
        ph_q   <= 6'd0;
        r_q[0] <= '0;
        r_q[1] <= '0;
      end
      S_MUL: begin
        // Magnitude times step in two partial products, on its low 32 bits and its upper bits.
        if (ph_q == 6'd0) begin
          prod_q <= 83'(mag[31:0]) * 83'(step_i);
          ph_q   <= 6'd1;
        end else begin
          prod_q <= prod_q + ((83'(mag[SumW+4:32]) * 83'(step_i)) << 32);
          ph_q   <= 6'd0;
        end
      end
      S_DIV: begin
        // First the range check, then the quotient; division by three or six uses a reciprocal.
        if (ph_q == 6'd0) begin
          n_q   <= nsh[32:0];
          big_q <= big;
          ph_q  <= 6'd1;
        end else begin
          if (!m_cur[SumW+4])
            r_q[part_q] <= (big_q || quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo;
          else
            r_q[part_q] <= big_q ? 32'h8000_0000 : -quo;
          part_q <= 1'b1;
          ph_q   <= 6'd0;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/matrix_sample_integrator.sv
// Top level of the matrix sample integrator: configuration registers and the two halves.
//
// Elements of complex square matrices arrive on the s_axis channel, one transaction per
// element, tagged with their flat position and a flag for the final sample. For each
// position the block keeps the first value, the previous value, a plain sum and a 4/2
// weighted sum. On every element of the final sample it sends the trapezoid or Simpson
// integral of that position on the m_axis channel; tlast marks the last position.
// Elements of other samples produce no output transaction.
// A result is formed in order: the element passes the queue, the store read and update,
// then, past the first sample, a multiply and a divide step per part. An element without a
// result frees the back end after its update, a final-sample one once its result is taken.
// A two-entry queue separates the front end from the back end, so the front keeps
// accepting while the back end works or while a result waits to be taken.
// If the receiver stalls, the result is held and the back end stops; the queue then
// fills and s_axis_tready falls. Elements at unused positions are dropped at once.
// Reset clears the sample count and the handshake state; the configuration returns to
// Simpson rule, step 1.0 and dimension 4. The stores hold nothing defined until the
// first sample writes them. Write registers over the APB port only while idle (not enforced).
`timescale 1ns / 1ps
module matrix_sample_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // elem_re [31:0], elem_im [63:32], elem_index [69:64]
  input  logic        s_axis_tuser,   // final_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // result_re [31:0], result_im [63:32], result_index [69:64]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msi_pkg::*;

  logic        rule_q;
  logic [31:0] step_q;
  logic [3:0]  dim_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= 1'b1;
      step_q <= 32'h0100_0000;
      dim_q  <= 4'd4;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegRule: rule_q <= pwdata[0];
        RegStep: step_q <= pwdata;
        RegDim:  dim_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRule: prdata = {31'd0, rule_q};
      RegStep: prdata = step_q;
      RegDim:  prdata = {28'd0, dim_q};
      default: prdata = '0;
    endcase
  end

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;
  logic [5:0] r_idx;
  logic signed [31:0] r_re, r_im;

  msi_front u_front (
    .clk_i, .rst_ni, .dim_i(dim_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .re_i(s_axis_tdata[31:0]), .im_i(s_axis_tdata[63:32]),
    .idx_i(s_axis_tdata[69:64]), .fin_i(s_axis_tuser),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  msi_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  msi_back u_back (
    .clk_i, .rst_ni, .rule_i(rule_q), .step_i(step_q),
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_re_o(r_re), .res_im_o(r_im), .res_idx_o(r_idx), .res_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, r_idx, r_im, r_re};

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // Back end takes a job only when the queue offers one.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_ready && !b_valid |=> !m_axis_tvalid)
    else $error("result without a job");
  // An element that is accepted and in use reaches the queue.
  a_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !f_ready |-> !s_axis_tready)
    else $error("element accepted while queue full");
endmodule
